[rtl/glyph_atlas_column_allocator_core_assert.svh]
// ----------------------------------------------------------------------------
// glyph atlas column allocator assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef GLYPH_ATLAS_COLUMN_ALLOCATOR_CORE_ASSERT_SVH
`define GLYPH_ATLAS_COLUMN_ALLOCATOR_CORE_ASSERT_SVH

// property that holds at every clock edge
`define GACA_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define GACA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/gaca_pkg.sv]
// ----------------------------------------------------------------------------
// gaca_pkg
// shared types, widths and parameter defaults of the glyph atlas allocator
// ----------------------------------------------------------------------------
package gaca_pkg;

    localparam int DIM_W  = 11;
    localparam int KEY_W  = 36;
    localparam int NEED_W = 12;

    localparam int TEXTURE_SIZE_DEF = 1024;
    localparam int PAD_DEF          = 1;
    localparam int SIZE_STEP_DEF    = 8;
    localparam int MAX_COLUMNS_DEF  = 64;
    localparam int MAX_GLYPHS_DEF   = 256;

    typedef enum logic [1:0] {
        ST_HIT   = 2'd0,
        ST_OLD   = 2'd1,
        ST_NEW   = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef logic [KEY_W-1:0] key_t;

    typedef struct packed {
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } region_t;

    typedef struct packed {
        logic    load;
        logic    idx_clr;
        logic    idx_inc;
        logic    x_add;
        logic    place_old;
        logic    place_new;
        logic    emit;
        status_t code;
    } gaca_cmd_t;

    typedef struct packed {
        logic key_end;
        logic key_match;
        logic glyph_full;
        logic col_end;
        logic col_fit;
        logic new_ok;
        logic out_free;
    } gaca_sts_t;

endpackage

[rtl/gaca_ctrl.sv]
// ----------------------------------------------------------------------------
// gaca_ctrl
// request sequencer: key store scan, column scan, placement and result
// ----------------------------------------------------------------------------
module gaca_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    output gaca_pkg::gaca_cmd_t cmd,
    input  gaca_pkg::gaca_sts_t sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_KREAD,
        S_KCMP,
        S_MISS,
        S_CREAD,
        S_CCMP
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = gaca_pkg::ST_HIT;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load    = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = S_KREAD;
                end
            end
            S_KREAD:
            begin
                state_next = sts.key_end ? S_MISS : S_KCMP;
            end
            S_KCMP:
            begin
                if (sts.key_match)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.code   = gaca_pkg::ST_HIT;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_KREAD;
                end
            end
            S_MISS:
            begin
                if (sts.glyph_full)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.code   = gaca_pkg::ST_FULL;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_CREAD;
                end
            end
            S_CREAD:
            begin
                if (!sts.col_end)
                begin
                    state_next = S_CCMP;
                end
                else if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.new_ok)
                    begin
                        cmd.place_new = 1'b1;
                        cmd.code      = gaca_pkg::ST_NEW;
                    end
                    else
                    begin
                        cmd.code = gaca_pkg::ST_FULL;
                    end
                    state_next = S_IDLE;
                end
            end
            S_CCMP:
            begin
                if (sts.col_fit)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.place_old = 1'b1;
                        cmd.code      = gaca_pkg::ST_OLD;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    cmd.x_add   = 1'b1;
                    cmd.idx_inc = 1'b1;
                    state_next  = S_CREAD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/gaca_dp.sv]
// ----------------------------------------------------------------------------
// gaca_dp
// key, region and column stores, scan index, x accumulator and result stage
// ----------------------------------------------------------------------------
`include "glyph_atlas_column_allocator_core_assert.svh"

module gaca_dp #(
    parameter int TEXTURE_SIZE = gaca_pkg::TEXTURE_SIZE_DEF,
    parameter int PAD          = gaca_pkg::PAD_DEF,
    parameter int SIZE_STEP    = gaca_pkg::SIZE_STEP_DEF,
    parameter int MAX_COLUMNS  = gaca_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_GLYPHS   = gaca_pkg::MAX_GLYPHS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [7:0]                  font_id,
    input  logic [15:0]                 glyph_index,
    input  logic [7:0]                  pixel_size,
    input  logic [3:0]                  border_width,
    input  logic [gaca_pkg::DIM_W-1:0]  bitmap_width,
    input  logic [gaca_pkg::DIM_W-1:0]  bitmap_height,
    input  gaca_pkg::gaca_cmd_t         cmd,
    output gaca_pkg::gaca_sts_t         sts,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output logic [1:0]                  status,
    output logic [gaca_pkg::DIM_W-1:0]  region_x,
    output logic [gaca_pkg::DIM_W-1:0]  region_y,
    output logic [gaca_pkg::DIM_W-1:0]  region_w,
    output logic [gaca_pkg::DIM_W-1:0]  region_h
);

    localparam int DW  = gaca_pkg::DIM_W;
    localparam int VW  = gaca_pkg::NEED_W;
    localparam int CW  = $clog2(TEXTURE_SIZE + 1);
    localparam int GCW = $clog2(MAX_GLYPHS + 1);
    localparam int GAW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
    localparam int CCW = $clog2(MAX_COLUMNS + 1);
    localparam int CAW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int IW  = (GCW > CCW) ? GCW : CCW;
    localparam int AW  = ((CW > VW) ? CW : VW) + 2;
    localparam int RSH = 20;
    localparam int RW  = RSH + 1;
    localparam int RCP = ((1 << RSH) + SIZE_STEP - 1) / SIZE_STEP;
    localparam int PW  = VW + RW;
    localparam int SW  = $clog2(SIZE_STEP + 1);
    localparam int QW  = VW + SW;

    localparam logic [AW-1:0] T_A  = AW'(TEXTURE_SIZE);
    localparam logic [AW-1:0] P_A  = AW'(PAD);
    localparam logic [AW-1:0] P2_A = AW'(2 * PAD);

    typedef struct packed {
        logic [CW-1:0] w;
        logic [CW-1:0] h;
    } col_t;

    gaca_pkg::key_t    key_mem [MAX_GLYPHS];
    gaca_pkg::region_t reg_mem [MAX_GLYPHS];
    col_t              col_mem [MAX_COLUMNS];

    gaca_pkg::key_t    key_reg;
    logic [DW-1:0]     w_reg;
    logic [DW-1:0]     h_reg;
    logic [VW-1:0]     q_reg;
    logic [VW-1:0]     need_reg;
    gaca_pkg::key_t    key_rd_reg;
    gaca_pkg::region_t reg_rd_reg;
    col_t              col_rd_reg;

    logic [IW-1:0]     idx_reg;
    logic [CW-1:0]     x_reg;
    logic [GCW-1:0]    glyph_count_reg;
    logic [CCW-1:0]    col_count_reg;

    logic              out_valid_reg;
    gaca_pkg::status_t status_reg;
    gaca_pkg::region_t out_reg;

    logic [VW-1:0]     round_v;
    logic [PW-1:0]     round_prod;
    logic [QW-1:0]     need_prod;
    logic [VW-1:0]     tall;
    logic [AW-1:0]     x_a;
    logic [AW-1:0]     cw_a;
    logic [AW-1:0]     ch_a;
    logic [AW-1:0]     need_a;
    logic [AW-1:0]     tall_a;
    logic              out_free;
    gaca_pkg::region_t new_region;
    logic [CAW-1:0]    col_wr_addr;
    col_t              col_wr_data;

    // round up to the size step by reciprocal multiply
    assign round_v    = VW'(w_reg) + VW'(SIZE_STEP - 1);
    assign round_prod = PW'(round_v) * PW'(RCP);
    assign need_prod  = QW'(q_reg) * QW'(SIZE_STEP);
    assign tall       = VW'(h_reg) + VW'(2 * PAD);

    assign x_a    = AW'(x_reg);
    assign cw_a   = AW'(col_rd_reg.w);
    assign ch_a   = AW'(col_rd_reg.h);
    assign need_a = AW'(need_reg);
    assign tall_a = AW'(tall);

    assign out_free = !out_valid_reg || !rsp_stall;

    assign sts.key_end    = (idx_reg == IW'(glyph_count_reg));
    assign sts.key_match  = (key_rd_reg == key_reg);
    assign sts.glyph_full = (glyph_count_reg == GCW'(MAX_GLYPHS));
    assign sts.col_end    = (idx_reg == IW'(col_count_reg));
    assign sts.col_fit    = (ch_a + tall_a <= T_A) && (cw_a >= need_a)
                            && (cw_a < (need_a << 1));
    assign sts.new_ok     = (col_count_reg < CCW'(MAX_COLUMNS))
                            && (x_a + need_a + P2_A < T_A) && (tall_a <= T_A);
    assign sts.out_free   = out_free;

    always_comb
    begin
        new_region.x = DW'(x_a + P_A);
        new_region.y = cmd.place_new ? DW'(PAD) : DW'(ch_a + P_A);
        new_region.w = w_reg;
        new_region.h = h_reg;
        if (cmd.place_new)
        begin
            col_wr_addr   = col_count_reg[CAW-1:0];
            col_wr_data.w = CW'(need_reg);
            col_wr_data.h = CW'(tall);
        end
        else
        begin
            col_wr_addr   = idx_reg[CAW-1:0];
            col_wr_data.w = col_rd_reg.w;
            col_wr_data.h = CW'(ch_a + tall_a);
        end
    end

    // stores
    always_ff @(posedge clk)
    begin
        if (cmd.place_old || cmd.place_new)
        begin
            key_mem[glyph_count_reg[GAW-1:0]] <= key_reg;
            reg_mem[glyph_count_reg[GAW-1:0]] <= new_region;
        end
        key_rd_reg <= key_mem[idx_reg[GAW-1:0]];
        reg_rd_reg <= reg_mem[idx_reg[GAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.place_old || cmd.place_new)
        begin
            col_mem[col_wr_addr] <= col_wr_data;
        end
        col_rd_reg <= col_mem[idx_reg[CAW-1:0]];
    end

    // item payload and result fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= {border_width, pixel_size, glyph_index, font_id};
            w_reg   <= bitmap_width;
            h_reg   <= bitmap_height;
        end
        q_reg    <= round_prod[RSH +: VW];
        need_reg <= need_prod[VW-1:0];
        if (cmd.emit)
        begin
            status_reg <= cmd.code;
            case (cmd.code)
                gaca_pkg::ST_HIT:  out_reg <= reg_rd_reg;
                gaca_pkg::ST_OLD:  out_reg <= new_region;
                gaca_pkg::ST_NEW:  out_reg <= new_region;
                gaca_pkg::ST_FULL: out_reg <= '0;
                default:           out_reg <= '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg         <= '0;
            x_reg           <= '0;
            glyph_count_reg <= '0;
            col_count_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
                x_reg   <= '0;
            end
            else
            begin
                if (cmd.idx_inc)
                begin
                    idx_reg <= idx_reg + IW'(1);
                end
                if (cmd.x_add)
                begin
                    x_reg <= CW'(x_a + cw_a + P2_A);
                end
            end
            if (cmd.place_old || cmd.place_new)
            begin
                glyph_count_reg <= glyph_count_reg + GCW'(1);
            end
            if (cmd.place_new)
            begin
                col_count_reg <= col_count_reg + CCW'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = out_valid_reg;
    assign status    = status_reg;
    assign region_x  = out_reg.x;
    assign region_y  = out_reg.y;
    assign region_w  = out_reg.w;
    assign region_h  = out_reg.h;

    `GACA_ASSERT_ALWAYS(a_glyph_bound, glyph_count_reg <= GCW'(MAX_GLYPHS), "glyph count over capacity")
    `GACA_ASSERT_ALWAYS(a_emit_free, !cmd.emit || out_free, "result written over a waiting item")
    `GACA_ASSERT_ALWAYS(a_place_emits, !(cmd.place_old || cmd.place_new) || cmd.emit, "placement without result")
    `GACA_ASSERT_NEXT(a_place_count, cmd.place_old || cmd.place_new, glyph_count_reg == $past(glyph_count_reg) + GCW'(1), "glyph count not advanced")
    `GACA_ASSERT_NEXT(a_col_hold, !cmd.place_new, $stable(col_count_reg), "column count moved without new column")

endmodule

[rtl/glyph_atlas_column_allocator_core.sv]
// a request ends in a registered result: a hit on a stored glyph, a placement in a scanned
// column, a new column, or no space after all columns or with a full key store
// each stored glyph and each column takes a store read state, then a compare state
// one request at a time; the next is taken the cycle after its result is registered
// reset: glyph and column counts clear at once, the stores need no clearing pass
// ----------------------------------------------------------------------------
// glyph_atlas_column_allocator_core
// glyph atlas region allocator with key cache and column packing
// ----------------------------------------------------------------------------
module glyph_atlas_column_allocator_core #(
    parameter int TEXTURE_SIZE = gaca_pkg::TEXTURE_SIZE_DEF,
    parameter int PAD          = gaca_pkg::PAD_DEF,
    parameter int SIZE_STEP    = gaca_pkg::SIZE_STEP_DEF,
    parameter int MAX_COLUMNS  = gaca_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_GLYPHS   = gaca_pkg::MAX_GLYPHS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic [7:0]                  font_id,
    input  logic [15:0]                 glyph_index,
    input  logic [7:0]                  pixel_size,
    input  logic [3:0]                  border_width,
    input  logic [gaca_pkg::DIM_W-1:0]  bitmap_width,
    input  logic [gaca_pkg::DIM_W-1:0]  bitmap_height,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output logic [1:0]                  status,
    output logic [gaca_pkg::DIM_W-1:0]  region_x,
    output logic [gaca_pkg::DIM_W-1:0]  region_y,
    output logic [gaca_pkg::DIM_W-1:0]  region_w,
    output logic [gaca_pkg::DIM_W-1:0]  region_h
);

    gaca_pkg::gaca_cmd_t cmd;
    gaca_pkg::gaca_sts_t sts;

    gaca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    gaca_dp #(
        .TEXTURE_SIZE (TEXTURE_SIZE),
        .PAD          (PAD),
        .SIZE_STEP    (SIZE_STEP),
        .MAX_COLUMNS  (MAX_COLUMNS),
        .MAX_GLYPHS   (MAX_GLYPHS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .font_id       (font_id),
        .glyph_index   (glyph_index),
        .pixel_size    (pixel_size),
        .border_width  (border_width),
        .bitmap_width  (bitmap_width),
        .bitmap_height (bitmap_height),
        .cmd           (cmd),
        .sts           (sts),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .region_x      (region_x),
        .region_y      (region_y),
        .region_w      (region_w),
        .region_h      (region_h)
    );

endmodule
